// File: design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define MTR_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
// Condition must never be true outside reset.
`define MTR_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define MTR_ASSERT(label, clk, rstn, prop)
`define MTR_NEVER(label, clk, rstn, cond)
`endif
`endif

// File: design/mtrng_pkg.sv
`timescale 1ns / 1ps
package mtrng_pkg;

    localparam int unsigned TW_SIZE   = 624;
    localparam int unsigned TW_SHIFT  = 397;
    localparam int unsigned ADDR_W    = 10;
    localparam int unsigned RES_W     = 53;

    localparam logic [31:0] TW_MATRIX = 32'h9908b0df;
    localparam logic [31:0] TW_UPPER  = 32'h80000000;
    localparam logic [31:0] TW_LOWER  = 32'h7fffffff;
    localparam logic [31:0] TEMPER_B  = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C  = 32'hefc60000;
    localparam logic [31:0] INIT_MULT = 32'd1812433253;
    localparam logic [31:0] MIX1_MULT = 32'd1664525;
    localparam logic [31:0] MIX2_MULT = 32'd1566083941;
    localparam logic [31:0] INIT_SEED = 32'd19650218;

    // request codes
    localparam logic [1:0] REQ_RESEED = 2'd0;
    localparam logic [1:0] REQ_RAW    = 2'd1;
    localparam logic [1:0] REQ_BOUND  = 2'd2;
    localparam logic [1:0] REQ_FRAC   = 2'd3;

    typedef logic [ADDR_W-1:0] addr_t;

    // output tempering
    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // leading zero count, input assumed nonzero
    function automatic logic [4:0] lead_zeros(input logic [31:0] n);
        logic [4:0] c;
        c = 5'd0;
        for (int b = 0; b < 32; b++) begin
            if (n[b]) begin
                c = 5'(31 - b);
            end
        end
        return c;
    endfunction

endpackage

// File: design/mersenne_twister_rng.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// MT19937 generator with the 624-word state held in one synchronous RAM.
// One request is worked on at a time. A raw word is read from the RAM,
// tempered and loaded into the output register once that register is
// free; the block is then idle for the next request. A fraction draws
// two words; a bounded draw repeats its word draw until the value falls
// below the bound. Every 624 words drawn the state is rebuilt in place,
// word by word through ST_GA, ST_GB and ST_GC, paced by the single read
// port. A reseed (request 0) writes the state three times over and
// returns zero. Draws before the first reseed give undefined values. The
// seed register may be written only while no request is in flight.
module mersenne_twister_rng
    import mtrng_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [31:0]      cfg_seed_value,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_req_type,
    input  logic [31:0]      s_upper_bound,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [RES_W-1:0] m_random_value
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_RA_MUL = 5'd1;
    localparam logic [4:0] ST_RA_WR  = 5'd2;
    localparam logic [4:0] ST_RB_RD  = 5'd3;
    localparam logic [4:0] ST_RB_WR  = 5'd4;
    localparam logic [4:0] ST_WRAP   = 5'd5;
    localparam logic [4:0] ST_FIN    = 5'd6;
    localparam logic [4:0] ST_G0     = 5'd7;
    localparam logic [4:0] ST_GINIT  = 5'd8;
    localparam logic [4:0] ST_GA     = 5'd9;
    localparam logic [4:0] ST_GB     = 5'd10;
    localparam logic [4:0] ST_GC     = 5'd11;
    localparam logic [4:0] ST_DRD    = 5'd12;
    localparam logic [4:0] ST_DTMP   = 5'd13;
    localparam logic [4:0] ST_DCHK   = 5'd14;
    localparam logic [4:0] ST_OUT    = 5'd15;

    localparam addr_t LAST_ADDR = addr_t'(TW_SIZE - 1);
    localparam addr_t SIZE_ADDR = addr_t'(TW_SIZE);
    localparam addr_t FAR_WRAP  = addr_t'(TW_SIZE - TW_SHIFT);

    // state store
    logic [31:0] mem [TW_SIZE];
    logic        mem_we;
    addr_t       mem_waddr, mem_raddr;
    logic [31:0] mem_wdata, mem_rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    logic [4:0]       state_reg, state_next;
    addr_t            pos_reg, pos_next;
    addr_t            idx_reg, idx_next;
    addr_t            cnt_reg, cnt_next;
    logic             phase_reg, phase_next;
    logic             half_reg, half_next;
    logic [31:0]      p_reg, p_next;
    logic [31:0]      prod_reg, prod_next;
    logic [31:0]      cur_reg, cur_next;
    logic [31:0]      nxt_reg, nxt_next;
    logic [31:0]      tmp_reg, tmp_next;
    logic [26:0]      a_reg, a_next;
    logic [1:0]       req_reg, req_next;
    logic [31:0]      bound_reg, bound_next;
    logic [4:0]       sh_reg, sh_next;
    logic [RES_W-1:0] res_reg, res_next;
    logic             m_valid_reg, m_valid_next;
    logic [RES_W-1:0] m_data_reg, m_data_next;
    logic [31:0]      seed_reg, seed_next;

    logic [31:0] mixed, wr_val, twist_y, twist_val, x_shift;
    addr_t       gen_nxt, gen_far;
    logic [4:0]  draw_start;

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_random_value = m_data_reg;

    assign mixed      = p_reg ^ (p_reg >> 30);
    assign wr_val     = phase_reg ? ((mem_rdata_reg ^ prod_reg) - 32'(idx_reg))
                                  : ((mem_rdata_reg ^ prod_reg) + seed_reg);
    assign gen_nxt    = (idx_reg == LAST_ADDR) ? '0 : idx_reg + 1'b1;
    assign gen_far    = (idx_reg < FAR_WRAP) ? addr_t'(idx_reg + addr_t'(TW_SHIFT))
                                             : addr_t'(idx_reg - FAR_WRAP);
    assign twist_y    = (cur_reg & TW_UPPER) | (nxt_reg & TW_LOWER);
    assign twist_val  = mem_rdata_reg ^ (twist_y >> 1) ^ (twist_y[0] ? TW_MATRIX : '0);
    assign x_shift    = tmp_reg >> sh_reg;
    assign draw_start = (pos_reg == SIZE_ADDR) ? ST_G0 : ST_DRD;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        phase_next   = phase_reg;
        half_next    = half_reg;
        p_next       = p_reg;
        prod_next    = prod_reg;
        cur_next     = cur_reg;
        nxt_next     = nxt_reg;
        tmp_next     = tmp_reg;
        a_next       = a_reg;
        req_next     = req_reg;
        bound_next   = bound_reg;
        sh_next      = sh_reg;
        res_next     = res_reg;
        seed_next    = (cfg_valid && cfg_ready) ? cfg_seed_value : seed_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg;
        mem_wdata    = wr_val;
        mem_raddr    = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = s_req_type;
                    bound_next = s_upper_bound;
                    sh_next    = lead_zeros(s_upper_bound);
                    half_next  = 1'b0;
                    case (s_req_type)
                        REQ_RESEED: begin
                            p_next     = INIT_SEED;
                            idx_next   = addr_t'(1);
                            state_next = ST_RA_MUL;
                        end
                        REQ_BOUND: begin
                            if (s_upper_bound == '0) begin
                                res_next   = '0;
                                state_next = ST_OUT;
                            end else begin
                                state_next = draw_start;
                            end
                        end
                        default: begin
                            state_next = draw_start;
                        end
                    endcase
                end
            end
            // linear fill from the fixed seed
            ST_RA_MUL: begin
                prod_next  = mixed * INIT_MULT;
                state_next = ST_RA_WR;
            end
            ST_RA_WR: begin
                mem_we    = 1'b1;
                mem_wdata = prod_reg + 32'(idx_reg);
                p_next    = prod_reg + 32'(idx_reg);
                if (idx_reg == LAST_ADDR) begin
                    idx_next   = addr_t'(1);
                    cnt_next   = SIZE_ADDR;
                    phase_next = 1'b0;
                    p_next     = INIT_SEED;
                    state_next = ST_RB_RD;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RA_MUL;
                end
            end
            // key mixing passes
            ST_RB_RD: begin
                mem_raddr  = idx_reg;
                prod_next  = mixed * (phase_reg ? MIX2_MULT : MIX1_MULT);
                state_next = ST_RB_WR;
            end
            ST_RB_WR: begin
                mem_we   = 1'b1;
                p_next   = wr_val;
                cnt_next = cnt_reg - 1'b1;
                if (idx_reg == LAST_ADDR) begin
                    idx_next   = addr_t'(1);
                    state_next = ST_WRAP;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    if (cnt_reg == addr_t'(1)) begin
                        if (phase_reg) begin
                            state_next = ST_FIN;
                        end else begin
                            phase_next = 1'b1;
                            cnt_next   = LAST_ADDR;
                            state_next = ST_RB_RD;
                        end
                    end else begin
                        state_next = ST_RB_RD;
                    end
                end
            end
            ST_WRAP: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = p_reg;
                if (cnt_reg == '0) begin
                    if (phase_reg) begin
                        state_next = ST_FIN;
                    end else begin
                        phase_next = 1'b1;
                        cnt_next   = LAST_ADDR;
                        state_next = ST_RB_RD;
                    end
                end else begin
                    state_next = ST_RB_RD;
                end
            end
            ST_FIN: begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = TW_UPPER;
                pos_next   = SIZE_ADDR;
                res_next   = '0;
                state_next = ST_OUT;
            end
            // in-place regeneration
            ST_G0: begin
                mem_raddr  = '0;
                idx_next   = '0;
                state_next = ST_GINIT;
            end
            ST_GINIT: begin
                cur_next   = mem_rdata_reg;
                mem_raddr  = gen_nxt;
                state_next = ST_GB;
            end
            ST_GA: begin
                mem_raddr  = gen_nxt;
                state_next = ST_GB;
            end
            ST_GB: begin
                nxt_next   = mem_rdata_reg;
                mem_raddr  = gen_far;
                state_next = ST_GC;
            end
            ST_GC: begin
                mem_we    = 1'b1;
                mem_wdata = twist_val;
                cur_next  = nxt_reg;
                if (idx_reg == LAST_ADDR) begin
                    pos_next   = '0;
                    state_next = ST_DRD;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_GA;
                end
            end
            // word draw
            ST_DRD: begin
                mem_raddr  = pos_reg;
                pos_next   = pos_reg + 1'b1;
                state_next = ST_DTMP;
            end
            ST_DTMP: begin
                tmp_next   = temper(mem_rdata_reg);
                state_next = ST_DCHK;
            end
            ST_DCHK: begin
                case (req_reg)
                    REQ_BOUND: begin
                        if (x_shift >= bound_reg) begin
                            state_next = draw_start;
                        end else begin
                            res_next   = RES_W'(x_shift);
                            state_next = ST_OUT;
                        end
                    end
                    REQ_FRAC: begin
                        if (!half_reg) begin
                            a_next     = tmp_reg[31:5];
                            half_next  = 1'b1;
                            state_next = draw_start;
                        end else begin
                            res_next   = {a_reg, tmp_reg[31:6]};
                            state_next = ST_OUT;
                        end
                    end
                    default: begin
                        res_next   = RES_W'(tmp_reg);
                        state_next = ST_OUT;
                    end
                endcase
            end
            // result register
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= SIZE_ADDR;
            m_valid_reg <= 1'b0;
            seed_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
            seed_reg    <= seed_next;
        end
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        phase_reg  <= phase_next;
        half_reg   <= half_next;
        p_reg      <= p_next;
        prod_reg   <= prod_next;
        cur_reg    <= cur_next;
        nxt_reg    <= nxt_next;
        tmp_reg    <= tmp_next;
        a_reg      <= a_next;
        req_reg    <= req_next;
        bound_reg  <= bound_next;
        sh_reg     <= sh_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    `MTR_NEVER(a_pos_range, aclk, aresetn, pos_reg > SIZE_ADDR)
    `MTR_NEVER(a_draw_in_range, aclk, aresetn, (state_reg == ST_DRD) && (pos_reg == SIZE_ADDR))
    `MTR_NEVER(a_write_in_range, aclk, aresetn, mem_we && (mem_waddr > LAST_ADDR))
    `MTR_ASSERT(a_regen_resets_pos, aclk, aresetn, (state_reg == ST_GC) && (idx_reg == LAST_ADDR) |=> (pos_reg == '0))

endmodule
